// ===== hdl/oblt_pkg.sv =====
// Shared types and constants for the order book level table.
package oblt_pkg;

    localparam int LEVELS_DEFAULT = 256;
    localparam int PRICE_W        = 48;
    localparam int QTY_W          = 48;
    localparam int SEQ_W          = 63;
    localparam int COUNT_W        = 9;
    localparam int IN_DATA_W      = 224;
    localparam int OUT_DATA_W     = 24;

    typedef enum logic [2:0] {
        ST_APPLIED  = 3'd0,
        ST_STALE    = 3'd1,
        ST_GAP      = 3'd2,
        ST_DROPPED  = 3'd3,
        ST_SNAPSHOT = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        VD_APPLY = 2'd0,
        VD_STALE = 2'd1,
        VD_GAP   = 2'd2
    } verdict_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_MATCH,
        FSM_OUT
    } fsm_t;

    // Command broadcast to every cell of one side.
    typedef struct packed {
        logic              clear;
        logic              write;
        logic              erase;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
    } cell_cmd_t;

    // Per-cell status returned to the controller.
    typedef struct packed {
        logic hit;
        logic valid;
    } cell_stat_t;

endpackage

// ===== hdl/oblt_cell.sv =====
// One table entry: price, quantity and valid bit with local match.
module oblt_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  oblt_pkg::cell_cmd_t cmd,
    input  logic               sel_free,
    input  logic               free_in,
    output logic               free_out,
    output oblt_pkg::cell_stat_t stat
);
    import oblt_pkg::*;

    logic [PRICE_W-1:0] price_reg;
    logic [QTY_W-1:0]   qty_reg;
    logic               valid_reg;
    logic               valid_eff;
    logic               hit;
    logic               take;

    // A clear in progress makes the cell look empty to this cycle's write
    assign valid_eff = valid_reg && !cmd.clear;
    assign hit  = valid_eff && (price_reg == cmd.price);
    // Free-slot token ripples down the chain; first empty cell keeps it.
    assign take     = free_in && !valid_eff;
    assign free_out = free_in && valid_eff;
    assign stat     = '{hit: hit, valid: valid_eff};

    // Valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.write && cmd.erase && hit)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.write && sel_free && take)
        begin
            valid_reg <= 1'b1;
        end
        else if (cmd.clear)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (cmd.write && !cmd.erase && (hit || (sel_free && take)))
        begin
            qty_reg <= cmd.qty;
            if (!hit)
            begin
                price_reg <= cmd.price;
            end
        end
    end
endmodule

// ===== hdl/oblt_side.sv =====
// One side of the book: a chain of cells with hit and free reduction.
module oblt_side #(
    parameter int LEVELS = oblt_pkg::LEVELS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  oblt_pkg::cell_cmd_t cmd,
    input  logic                sel_free,
    output logic                any_hit,
    output logic                any_free
);
    import oblt_pkg::*;

    logic [LEVELS:0]   chain;
    logic [LEVELS-1:0] hits;
    cell_stat_t        stats [LEVELS];

    assign chain[0] = 1'b1;

    genvar g;
    generate
        for (g = 0; g < LEVELS; g++)
        begin : g_cell
            oblt_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cmd      (cmd),
                .sel_free (sel_free),
                .free_in  (chain[g]),
                .free_out (chain[g+1]),
                .stat     (stats[g])
            );
            assign hits[g] = stats[g].hit;
        end
    endgenerate

    assign any_hit  = |hits;
    assign any_free = !chain[LEVELS];
endmodule

// ===== hdl/order_book_level_table.sv =====
// Top level: sequence check, two cell chains, count registers, output stage.
// An accepted item is matched and written in the match state and its result shown in
// the output state, one at a time (accept, match and write, result); a held result
// keeps the input closed. The match cycle compares the price in every cell of a side.
// Reset (rst_n, async low) clears valid bits, counts, last id and verdict.
// Tables need no clearing pass.
module order_book_level_table #(
    parameter int LEVELS_PER_SIDE = oblt_pkg::LEVELS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // op, side, price, quantity, first_seq_id, final_seq_id
    input  logic [oblt_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // has_level, first_in_group
    input  logic [1:0]                     s_axis_tuser,
    input  logic                           s_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // status, bid_levels, ask_levels, 3 zero bits
    output logic [oblt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                           m_axis_tlast
);
    import oblt_pkg::*;

    localparam int CW = $clog2(LEVELS_PER_SIDE + 1);

    fsm_t state_reg, state_next;
    logic                op_reg, side_reg, has_reg, first_reg, last_reg;
    logic [PRICE_W-1:0]  price_reg;
    logic [QTY_W-1:0]    qty_reg;
    logic [SEQ_W-1:0]    first_id_reg, final_id_reg;
    logic [SEQ_W-1:0]    last_seq_reg;
    verdict_t            verdict_reg;
    logic [CW-1:0]       bid_cnt_reg, ask_cnt_reg;
    logic [CW-1:0]       bid_cnt_next, ask_cnt_next;
    logic [2:0]          status_reg;
    logic                olast_reg;

    logic      in_acc, do_work;
    verdict_t  verdict_now;
    logic      snap_clear;
    logic      apply, erase, insert;
    cell_cmd_t bid_cmd, ask_cmd;
    logic      bid_hit, bid_free, ask_hit, ask_free;
    logic      hit, free_ok, full;
    logic [CW-1:0] cnt_sel;
    logic [2:0] status_now;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign do_work = (state_reg == FSM_MATCH);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE:  if (s_axis_tvalid) state_next = FSM_MATCH;
            FSM_MATCH: state_next = FSM_OUT;
            FSM_OUT:   if (m_axis_tready) state_next = FSM_IDLE;
            default:   state_next = FSM_IDLE;
        endcase
    end

    // Outputs of the state machine
    always_comb
    begin
        s_axis_tready = (state_reg == FSM_IDLE);
        m_axis_tvalid = (state_reg == FSM_OUT);
    end

    // Sequence check for an update's first item
    always_comb
    begin
        if (!first_reg || !op_reg)
            verdict_now = verdict_reg;
        else if (final_id_reg <= last_seq_reg)
            verdict_now = VD_STALE;
        else if ({1'b0, first_id_reg} > ({1'b0, last_seq_reg} + 64'd1))
            verdict_now = VD_GAP;
        else
            verdict_now = VD_APPLY;
        if (!op_reg && first_reg)
            verdict_now = VD_APPLY;
    end

    // Cells are cleared in the match cycle for a snapshot start; the write
    // follows in the same cycle since cleared cells show no hit and all free.
    // Snapshot levels are stored whatever the verdict.
    assign snap_clear = do_work && !op_reg && first_reg;
    assign erase      = op_reg && (qty_reg == '0);
    assign apply      = do_work && has_reg && (!op_reg || verdict_now == VD_APPLY);

    assign hit     = side_reg ? ask_hit : bid_hit;
    assign free_ok = snap_clear ? 1'b1 : (side_reg ? ask_free : bid_free);
    assign cnt_sel = snap_clear ? '0 : (side_reg ? ask_cnt_reg : bid_cnt_reg);
    assign full    = !free_ok || (cnt_sel >= CW'(LEVELS_PER_SIDE));
    // New price goes to the lowest free cell
    assign insert  = !erase && !hit && !full;

    always_comb
    begin
        bid_cmd.clear = snap_clear;
        bid_cmd.price = price_reg;
        bid_cmd.qty   = qty_reg;
        bid_cmd.erase = erase;
        bid_cmd.write = apply && !side_reg;
        ask_cmd       = bid_cmd;
        ask_cmd.write = apply && side_reg;
    end

    oblt_side #(.LEVELS(LEVELS_PER_SIDE)) u_bid (
        .clk(clk), .rst_n(rst_n), .cmd(bid_cmd), .sel_free(insert),
        .any_hit(bid_hit), .any_free(bid_free)
    );
    oblt_side #(.LEVELS(LEVELS_PER_SIDE)) u_ask (
        .clk(clk), .rst_n(rst_n), .cmd(ask_cmd), .sel_free(insert),
        .any_hit(ask_hit), .any_free(ask_free)
    );

    // Status of the item
    always_comb
    begin
        if (op_reg && verdict_now != VD_APPLY)
            status_now = {1'b0, verdict_now};
        else if (has_reg && !erase && !hit && full)
            status_now = ST_DROPPED;
        else if (!op_reg)
            status_now = ST_SNAPSHOT;
        else
            status_now = ST_APPLIED;
    end

    // Level counts after this item
    always_comb
    begin
        bid_cnt_next = snap_clear ? '0 : bid_cnt_reg;
        ask_cnt_next = snap_clear ? '0 : ask_cnt_reg;
        if (apply && erase && hit)
        begin
            if (side_reg) ask_cnt_next = ask_cnt_reg - CW'(1);
            else          bid_cnt_next = bid_cnt_reg - CW'(1);
        end
        else if (apply && insert)
        begin
            if (side_reg) ask_cnt_next = cnt_sel + CW'(1);
            else          bid_cnt_next = cnt_sel + CW'(1);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= FSM_IDLE;
            last_seq_reg <= '0;
            verdict_reg  <= VD_APPLY;
            bid_cnt_reg  <= '0;
            ask_cnt_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            bid_cnt_reg <= bid_cnt_next;
            ask_cnt_reg <= ask_cnt_next;
            if (do_work)
            begin
                verdict_reg <= verdict_now;
                if (snap_clear)
                    last_seq_reg <= final_id_reg;
                else if (op_reg && last_reg && verdict_now == VD_APPLY)
                    last_seq_reg <= final_id_reg;
            end
        end
    end

    // Input capture and result register
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            op_reg       <= s_axis_tdata[0];
            side_reg     <= s_axis_tdata[1];
            price_reg    <= s_axis_tdata[49:2];
            qty_reg      <= s_axis_tdata[97:50];
            first_id_reg <= s_axis_tdata[160:98];
            final_id_reg <= s_axis_tdata[223:161];
            has_reg      <= s_axis_tuser[0];
            first_reg    <= s_axis_tuser[1];
            last_reg     <= s_axis_tlast;
        end
        if (do_work)
        begin
            status_reg <= status_now;
            olast_reg  <= last_reg;
        end
    end

    // Result item: status, then bid and ask counts after this item
    assign m_axis_tlast = olast_reg;
    assign m_axis_tdata = {3'b000, COUNT_W'(ask_cnt_reg), COUNT_W'(bid_cnt_reg), status_reg};
endmodule

// ===== hdl/oblt_checker.sv =====
// Port-level checker for the order book level table, bound to the top level.
module oblt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);
    // No new item while a result waits
    a_one_at_time: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while result pending");

    // Status code stays in range
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2:0] <= 3'd4))
        else $error("bad status");

    // A result is valid once an accepted item has passed through the match state
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> ##1 m_axis_tvalid)
        else $error("result missing");

    // Result holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped");
endmodule

bind order_book_level_table oblt_checker u_oblt_checker (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
